@@ hdl/kvm_pkg.sv @@
`timescale 1ns / 1ps

package kvm_pkg;

    localparam int FIELD_BITS = 32;
    localparam int COUNT_BITS = 5;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_SET    = 2'd2,
        FUNC_GET    = 2'd3
    } kvm_func_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_PRESENT   = 2'd3
    } kvm_status_t;

    typedef struct packed {
        kvm_func_t               func;
        logic [FIELD_BITS-1:0]   key;
        logic [FIELD_BITS-1:0]   value;
    } kvm_req_t;

    typedef struct packed {
        kvm_status_t             status;
        logic                    found;
        logic [FIELD_BITS-1:0]   value_out;
        logic [COUNT_BITS-1:0]   entry_count;
        logic                    is_empty;
    } kvm_rsp_t;

endpackage

@@ hdl/kvm_store.sv @@
`timescale 1ns / 1ps

module kvm_store
#(
    parameter int ENTRIES = 16,
    parameter int KEY_W   = 32,
    parameter int VAL_W   = 32,
    parameter int AW      = 4
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic             rd_vld,
    output logic [KEY_W-1:0] rd_key,
    output logic [VAL_W-1:0] rd_value,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic             wr_vld,
    input  logic [KEY_W-1:0] wr_key,
    input  logic [VAL_W-1:0] wr_value
);

    logic             vld_mem [ENTRIES];
    logic [KEY_W-1:0] key_mem [ENTRIES];
    logic [VAL_W-1:0] val_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            vld_mem[wr_addr] <= wr_vld;
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_vld   <= vld_mem[rd_addr];
            rd_key   <= key_mem[rd_addr];
            rd_value <= val_mem[rd_addr];
        end
    end

endmodule

@@ hdl/kvm_seq.sv @@
`timescale 1ns / 1ps

module kvm_seq
    import kvm_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int KEY_W   = 32,
    parameter int VAL_W   = 32,
    parameter int AW      = 4,
    parameter int CW      = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  kvm_req_t         req_data,
    output logic             res_valid,
    input  logic             res_ready,
    output kvm_rsp_t         res_data,
    output logic             rd_en,
    output logic [AW-1:0]    rd_addr,
    input  logic             rd_vld,
    input  logic [KEY_W-1:0] rd_key,
    input  logic [VAL_W-1:0] rd_value,
    output logic             wr_en,
    output logic [AW-1:0]    wr_addr,
    output logic             wr_vld,
    output logic [KEY_W-1:0] wr_key,
    output logic [VAL_W-1:0] wr_value
);

    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_FINISH} state_t;

    state_t           state_reg, state_next;
    kvm_func_t        func_reg, func_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [AW-1:0]    issue_reg, issue_next;
    logic             issued_all_reg, issued_all_next;
    logic             chk_reg, chk_next;
    logic [AW-1:0]    chk_addr_reg, chk_addr_next;
    logic             hit_reg, hit_next;
    logic [AW-1:0]    hit_addr_reg, hit_addr_next;
    logic [VAL_W-1:0] hit_val_reg, hit_val_next;
    logic             free_reg, free_next;
    logic [AW-1:0]    free_addr_reg, free_addr_next;
    logic [CW-1:0]    count_reg, count_next;

    logic                       hit_now;
    logic                       free_now;
    logic [VAL_W+FIELD_BITS-1:0] val_ext;

    // shared slot comparator, fed by the registered memory read
    assign hit_now  = chk_reg && rd_vld && (rd_key == key_reg);
    assign free_now = chk_reg && !rd_vld;

    assign req_ready = (state_reg == S_IDLE);
    assign rd_en     = (state_reg == S_SCAN) && !issued_all_reg;
    assign rd_addr   = issue_reg;
    assign res_valid = (state_reg == S_FINISH);
    assign val_ext   = {{FIELD_BITS{1'b0}}, hit_val_reg};

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        issue_next      = issue_reg;
        issued_all_next = issued_all_reg;
        chk_next        = 1'b0;
        chk_addr_next   = chk_addr_reg;
        hit_next        = hit_reg;
        hit_addr_next   = hit_addr_reg;
        hit_val_next    = hit_val_reg;
        free_next       = free_reg;
        free_addr_next  = free_addr_reg;
        count_next      = count_reg;
        wr_en           = 1'b0;
        wr_addr         = issue_reg;
        wr_vld          = 1'b0;
        wr_key          = key_reg;
        wr_value        = val_reg;
        res_data        = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en      = 1'b1;
                issue_next = issue_reg + 1'b1;
                if (issue_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next       = req_data.func;
                    key_next        = req_data.key[KEY_W-1:0];
                    val_next        = req_data.value[VAL_W-1:0];
                    issue_next      = '0;
                    issued_all_next = 1'b0;
                    hit_next        = 1'b0;
                    free_next       = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    chk_next      = 1'b1;
                    chk_addr_next = issue_reg;
                    issue_next    = issue_reg + 1'b1;
                    if (issue_reg == LAST)
                    begin
                        issued_all_next = 1'b1;
                    end
                end
                // remember the lowest empty slot for a later add
                if (free_now && !free_reg)
                begin
                    free_next      = 1'b1;
                    free_addr_next = chk_addr_reg;
                end
                if (hit_now)
                begin
                    hit_next      = 1'b1;
                    hit_addr_next = chk_addr_reg;
                    hit_val_next  = rd_value;
                    state_next    = S_FINISH;
                end
                else if (chk_reg && chk_addr_reg == LAST)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                res_data.found  = hit_reg;
                res_data.status = ST_DONE;
                unique case (func_reg)
                    FUNC_ADD:
                    begin
                        if (hit_reg)
                        begin
                            res_data.status = ST_PRESENT;
                        end
                        else if (!free_reg)
                        begin
                            res_data.status = ST_FULL;
                        end
                        else
                        begin
                            wr_en      = res_ready;
                            wr_addr    = free_addr_reg;
                            wr_vld     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    FUNC_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            wr_en              = res_ready;
                            wr_addr            = hit_addr_reg;
                            wr_vld             = 1'b0;
                            count_next         = count_reg - 1'b1;
                            res_data.value_out = val_ext[FIELD_BITS-1:0];
                        end
                        else
                        begin
                            res_data.status = ST_NOT_FOUND;
                        end
                    end
                    FUNC_SET:
                    begin
                        if (hit_reg)
                        begin
                            wr_en   = res_ready;
                            wr_addr = hit_addr_reg;
                            wr_vld  = 1'b1;
                        end
                        else
                        begin
                            res_data.status = ST_NOT_FOUND;
                        end
                    end
                    FUNC_GET:
                    begin
                        if (hit_reg)
                        begin
                            res_data.value_out = val_ext[FIELD_BITS-1:0];
                        end
                        else
                        begin
                            res_data.status = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        res_data.status = ST_NOT_FOUND;
                    end
                endcase
                res_data.entry_count = COUNT_BITS'(count_next);
                res_data.is_empty    = (count_next == '0);
                // hold the count until the result is taken
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    count_next = count_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            issue_reg      <= '0;
            issued_all_reg <= 1'b0;
            chk_reg        <= 1'b0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            issued_all_reg <= issued_all_next;
            chk_reg        <= chk_next;
            hit_reg        <= hit_next;
            free_reg       <= free_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        chk_addr_reg  <= chk_addr_next;
        hit_addr_reg  <= hit_addr_next;
        hit_val_reg   <= hit_val_next;
        free_addr_reg <= free_addr_next;
    end

endmodule

@@ hdl/key_value_map_table.sv @@
`timescale 1ns / 1ps

// Channel   Handshake               Payload     Moves
// request   req_valid / req_ready   req_data    func, key, value
// result    rsp_valid / rsp_ready   rsp_data    status, found, value_out, entry_count, is_empty
//
// After reset a clearing pass writes every slot invalid while req_ready stays low.
// Between one accept and the next, a request makes one memory read per slot through a
// single key comparator, drains the last read, then writes back and offers its result.
// A hit ends the scan early. The result sits in an output register, so a stalled result
// lets the following request scan but holds its write-back, its result and the next accept.

module key_value_map_table
    import kvm_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  kvm_req_t req_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output kvm_rsp_t rsp_data
);

    localparam int KEY_W = (KEY_BITS < FIELD_BITS) ? KEY_BITS : FIELD_BITS;
    localparam int VAL_W = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW    = $clog2(ENTRIES + 1);

    logic             res_valid;
    logic             res_ready;
    kvm_rsp_t         res_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             rd_vld;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_value;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic             wr_vld;
    logic [KEY_W-1:0] wr_key;
    logic [VAL_W-1:0] wr_value;
    logic             rsp_valid_reg;
    kvm_rsp_t         rsp_data_reg;

    kvm_seq
    #(
        .ENTRIES (ENTRIES),
        .KEY_W   (KEY_W),
        .VAL_W   (VAL_W),
        .AW      (AW),
        .CW      (CW)
    )
    u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_vld    (rd_vld),
        .rd_key    (rd_key),
        .rd_value  (rd_value),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_vld    (wr_vld),
        .wr_key    (wr_key),
        .wr_value  (wr_value)
    );

    kvm_store
    #(
        .ENTRIES (ENTRIES),
        .KEY_W   (KEY_W),
        .VAL_W   (VAL_W),
        .AW      (AW)
    )
    u_store
    (
        .clk      (clk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_vld   (rd_vld),
        .rd_key   (rd_key),
        .rd_value (rd_value),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_vld   (wr_vld),
        .wr_key   (wr_key),
        .wr_value (wr_value)
    );

    assign res_ready = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_data_reg <= res_data;
        end
    end

endmodule

@@ hdl/kvm_checker.sv @@
`timescale 1ns / 1ps

module kvm_checker
    import kvm_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input kvm_req_t req_data,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input kvm_rsp_t rsp_data
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    // one request at a time: busy right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.is_empty |-> rsp_data.entry_count == '0)
        else $error("empty flag with nonzero count");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == ST_NOT_FOUND |->
            !rsp_data.found && rsp_data.value_out == '0)
        else $error("missing key reported a value");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == ST_PRESENT |-> rsp_data.found)
        else $error("present key without found flag");

endmodule

bind key_value_map_table kvm_checker u_kvm_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);

@@ tb/kvm_table_checker.sv @@
`timescale 1ns / 1ps

module kvm_table_checker
    import kvm_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_ready,
    input  kvm_req_t req_data,
    input  logic     rsp_valid,
    input  logic     rsp_ready,
    input  kvm_rsp_t rsp_data,
    output int       fail_count,
    output int       pending
);

    logic [FIELD_BITS-1:0] shadow_key [SLOTS];
    logic [FIELD_BITS-1:0] shadow_val [SLOTS];
    logic                  shadow_used [SLOTS];
    int                    shadow_count;

    kvm_rsp_t awaited_results [$];

    // Apply one request to the shadow table and return the result it yields.
    function automatic kvm_rsp_t apply_table_op(kvm_req_t r);
        kvm_rsp_t res;
        int       hit;
        int       spare;
        int       i;
        hit   = -1;
        spare = -1;
        for (i = SLOTS - 1; i >= 0; i--)
        begin
            if (shadow_used[i] && shadow_key[i] == r.key)
                hit = i;
            if (!shadow_used[i])
                spare = i;
        end
        res.status    = ST_DONE;
        res.found     = (hit >= 0);
        res.value_out = '0;
        if (r.func == FUNC_ADD)
        begin
            if (hit >= 0)
                res.status = ST_PRESENT;
            else if (spare < 0)
                res.status = ST_FULL;
            else
            begin
                shadow_key[spare]  = r.key;
                shadow_val[spare]  = r.value;
                shadow_used[spare] = 1'b1;
                shadow_count++;
            end
        end
        else if (hit < 0)
            res.status = ST_NOT_FOUND;
        else
        begin
            case (r.func)
                FUNC_REMOVE:
                begin
                    res.value_out    = shadow_val[hit];
                    shadow_used[hit] = 1'b0;
                    if (shadow_count > 0)
                        shadow_count--;
                end
                FUNC_SET:
                    shadow_val[hit] = r.value;
                default:
                    res.value_out = shadow_val[hit];
            endcase
        end
        res.entry_count = shadow_count[COUNT_BITS-1:0];
        res.is_empty    = (shadow_count == 0);
        return res;
    endfunction

    task automatic report_field(input string field, input logic [31:0] exp_v,
                                input logic [31:0] got_v);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, got_v);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        kvm_rsp_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                shadow_key[i]  = '0;
                shadow_val[i]  = '0;
                shadow_used[i] = 1'b0;
            end
            shadow_count = 0;
            awaited_results.delete();
            pending <= 0;
        end
        else
        begin
            // Retire the result first: it can only belong to an earlier request.
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, rsp_data);
                    fail_count++;
                end
                else
                begin
                    exp_r = awaited_results.pop_front();
                    if (rsp_data.status !== exp_r.status)
                        report_field("status", 32'(exp_r.status), 32'(rsp_data.status));
                    if (rsp_data.found !== exp_r.found)
                        report_field("found", 32'(exp_r.found), 32'(rsp_data.found));
                    if (rsp_data.value_out !== exp_r.value_out)
                        report_field("value_out", exp_r.value_out, rsp_data.value_out);
                    if (rsp_data.entry_count !== exp_r.entry_count)
                        report_field("entry_count", 32'(exp_r.entry_count),
                                     32'(rsp_data.entry_count));
                    if (rsp_data.is_empty !== exp_r.is_empty)
                        report_field("is_empty", 32'(exp_r.is_empty),
                                     32'(rsp_data.is_empty));
                end
            end
            if (req_valid && req_ready)
                awaited_results.push_back(apply_table_op(req_data));
            pending <= awaited_results.size();
        end
    end

endmodule

@@ tb/key_value_map_table_tb.sv @@
`timescale 1ns / 1ps

module key_value_map_table_tb;
    import kvm_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int POOL_KEYS    = 24;
    localparam int RANDOM_ITEMS = 775;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    kvm_req_t req_data;
    logic     rsp_valid;
    logic     rsp_ready;
    kvm_rsp_t rsp_data;

    int fail_count;
    int pending;
    int reqs_taken;

    logic [FIELD_BITS-1:0] key_pool [POOL_KEYS];

    key_value_map_table #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (FIELD_BITS),
        .VALUE_BITS (FIELD_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    kvm_table_checker #(
        .SLOTS (ENTRIES)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_data   (rsp_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            reqs_taken <= 0;
        else if (req_valid && req_ready)
            reqs_taken <= reqs_taken + 1;
    end

    // Hold the request until the block takes it; returns right after that edge.
    task automatic send_req(input kvm_func_t f, input logic [FIELD_BITS-1:0] k,
                            input logic [FIELD_BITS-1:0] v);
        req_data.func  <= f;
        req_data.key   <= k;
        req_data.value <= v;
        req_valid      <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Receiver: switch between stall patterns, with one long hold-off mid-run.
    initial
    begin
        int  stall_left;
        int  mode_left;
        int  mode;
        bit  long_done;
        rsp_ready  = 1'b0;
        stall_left = 0;
        mode_left  = 0;
        mode       = 0;
        long_done  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!long_done && reqs_taken >= 300)
            begin
                long_done  = 1'b1;
                stall_left = 400;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 150);
            end
            mode_left--;
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= 1'($urandom_range(0, 1));
                    default: rsp_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial
    begin
        int                    sent;
        int                    burst_left;
        int                    bias;
        int                    gap;
        int                    roll;
        int                    add_lim;
        int                    rem_lim;
        int                    set_lim;
        bit                    mid_drained;
        kvm_func_t             f;
        logic [FIELD_BITS-1:0] k;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req_data    = '0;
        mid_drained = 1'b0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_KEYS; i++)
            key_pool[i] = $urandom();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Misses on an empty table, then extreme keys and values.
        send_req(FUNC_GET, key_pool[0], 32'h1234_5678);
        send_req(FUNC_REMOVE, key_pool[1], '1);
        send_req(FUNC_SET, key_pool[0], '1);
        send_req(FUNC_ADD, key_pool[0], '1);
        send_req(FUNC_ADD, key_pool[1], '0);
        send_req(FUNC_ADD, key_pool[0], 32'h5555_AAAA);
        send_req(FUNC_SET, key_pool[0], 32'hA5A5_5A5A);
        send_req(FUNC_GET, key_pool[0], '0);
        send_req(FUNC_REMOVE, key_pool[1], '0);
        send_req(FUNC_GET, key_pool[1], '0);
        // Fill every slot, then try one more add.
        for (int i = 2; i <= ENTRIES; i++)
            send_req(FUNC_ADD, key_pool[i], $urandom());
        send_req(FUNC_ADD, key_pool[ENTRIES + 1], $urandom());
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst_left = $urandom_range(1, 12);
            bias       = $urandom_range(0, 2);
            case (bias)
                0:       begin add_lim = 55; rem_lim = 65; set_lim = 80; end
                1:       begin add_lim = 30; rem_lim = 55; set_lim = 75; end
                default: begin add_lim = 15; rem_lim = 60; set_lim = 75; end
            endcase
            while (burst_left > 0 && sent < RANDOM_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < add_lim)
                    f = FUNC_ADD;
                else if (roll < rem_lim)
                    f = FUNC_REMOVE;
                else if (roll < set_lim)
                    f = FUNC_SET;
                else
                    f = FUNC_GET;
                // Adds stay inside the pool so the table never clogs with stray keys.
                if (f != FUNC_ADD && $urandom_range(0, 9) == 0)
                    k = $urandom();
                else
                    k = key_pool[$urandom_range(0, POOL_KEYS - 1)];
                send_req(f, k, $urandom());
                sent++;
                burst_left--;
            end
            if (!mid_drained && sent >= RANDOM_ITEMS / 2)
            begin
                mid_drained = 1'b1;
                wait_drained();
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS key_value_map_table");
        else
            $display("FAIL key_value_map_table");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL key_value_map_table");
        $finish;
    end

endmodule

@@ key_value_map_table.f @@
hdl/kvm_pkg.sv
hdl/kvm_store.sv
hdl/kvm_seq.sv
hdl/key_value_map_table.sv
hdl/kvm_checker.sv
tb/kvm_table_checker.sv
tb/key_value_map_table_tb.sv
